// ===== hdl/stbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted-table binary search: shared definitions
// Field widths, item kind codes, the search state type and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package stbs_pkg;

  localparam int unsigned SLOT_W  = 8;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned NAME_W  = 64;
  localparam int unsigned POS_W   = 8;

  // Item kind codes.
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_MISS
  } search_state_e;

  typedef struct packed {
    logic              found;
    logic [POS_W-1:0]  position;
    logic [NAME_W-1:0] name;
  } result_t;

endpackage : stbs_pkg

`default_nettype wire

// ===== hdl/stbs_ram.sv =====
// ----------------------------------------------------------------------------
// Sorted-table binary search: table memory
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // The read data holds its value while no read is issued.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule : stbs_ram

`default_nettype wire

// ===== hdl/stbs_search.sv =====
// ----------------------------------------------------------------------------
// Sorted-table binary search: search sequencer
// Walks the bounds one probe per cycle and holds the result for the output.
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_search #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned KEY_BYTES   = 8,
  parameter int unsigned NAME_BYTES  = 8
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // Search start, taken only while idle.
  input  wire logic                                 start_i,
  input  wire logic [8*KEY_BYTES-1:0]               query_i,
  input  wire logic [stbs_pkg::COUNT_W-1:0]         entry_count_i,
  output logic                                      idle_o,
  // Memory read port.
  output logic                                      rd_en_o,
  output logic      [$clog2(TABLE_DEPTH)-1:0]       rd_addr_o,
  input  wire logic [8*KEY_BYTES-1:0]               rd_key_i,
  input  wire logic [8*NAME_BYTES-1:0]              rd_name_i,
  // Result register.
  output logic                                      res_valid_o,
  input  wire logic                                 res_ready_i,
  output stbs_pkg::result_t                         res_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned BW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CW = (BW > stbs_pkg::COUNT_W) ? BW : stbs_pkg::COUNT_W;
  localparam int unsigned KW = 8 * KEY_BYTES;

  stbs_pkg::search_state_e state_q, state_d;
  logic [BW-1:0]     lo_q, lo_d, hi_q, hi_d;
  logic [AW-1:0]     probe_q, probe_d;
  logic [KW-1:0]     query_q;
  logic              res_valid_q, res_valid_d;
  stbs_pkg::result_t res_q, res_d;

  logic [CW-1:0]     count_ext;
  logic [BW-1:0]     count_sat;
  logic              out_free;
  logic              hit, greater;
  logic [BW-1:0]     next_lo, next_hi;
  logic [AW+7:0]     probe_ext;
  logic              res_load;

  // Inclusive midpoint of a non-empty range with exclusive upper bound.
  function automatic logic [AW-1:0] mid_of(logic [BW-1:0] lo, logic [BW-1:0] hi);
    logic [BW:0] s;
    s = {1'b0, lo} + {1'b0, hi} - (BW+1)'(1);
    return s[AW:1];
  endfunction

  assign count_ext = CW'(entry_count_i);
  assign count_sat = (count_ext > CW'(TABLE_DEPTH)) ? BW'(TABLE_DEPTH) : count_ext[BW-1:0];
  assign out_free  = !res_valid_q || res_ready_i;
  assign hit       = (rd_key_i == query_q);
  assign greater   = (rd_key_i > query_q);
  assign next_lo   = greater ? lo_q : (BW'(probe_q) + BW'(1));
  assign next_hi   = greater ? BW'(probe_q) : hi_q;
  assign probe_ext = {8'd0, probe_q};

  always_comb begin
    state_d   = state_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    probe_d   = probe_q;
    rd_en_o   = 1'b0;
    rd_addr_o = probe_q;
    res_load  = 1'b0;
    res_d     = res_q;
    case (state_q)
      stbs_pkg::ST_IDLE: begin
        if (start_i) begin
          lo_d = '0;
          hi_d = count_sat;
          if (count_sat != '0) begin
            rd_en_o   = 1'b1;
            rd_addr_o = mid_of('0, count_sat);
            probe_d   = rd_addr_o;
            state_d   = stbs_pkg::ST_PROBE;
          end else begin
            state_d = stbs_pkg::ST_MISS;
          end
        end
      end
      stbs_pkg::ST_PROBE: begin
        if (hit) begin
          if (out_free) begin
            res_load       = 1'b1;
            res_d.found    = 1'b1;
            res_d.position = probe_ext[7:0];
            res_d.name     = stbs_pkg::NAME_W'(rd_name_i);
            state_d        = stbs_pkg::ST_IDLE;
          end
        end else if (next_lo < next_hi) begin
          lo_d      = next_lo;
          hi_d      = next_hi;
          rd_en_o   = 1'b1;
          rd_addr_o = mid_of(next_lo, next_hi);
          probe_d   = rd_addr_o;
        end else if (out_free) begin
          res_load = 1'b1;
          res_d    = '0;
          state_d  = stbs_pkg::ST_IDLE;
        end
      end
      stbs_pkg::ST_MISS: begin
        if (out_free) begin
          res_load = 1'b1;
          res_d    = '0;
          state_d  = stbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = stbs_pkg::ST_IDLE;
      end
    endcase
    res_valid_d = res_load ? 1'b1 : (res_ready_i ? 1'b0 : res_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stbs_pkg::ST_IDLE;
      lo_q        <= '0;
      hi_q        <= '0;
      probe_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      probe_q     <= probe_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && state_q == stbs_pkg::ST_IDLE) begin
      query_q <= query_i;
    end
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign idle_o      = (state_q == stbs_pkg::ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // A read is only issued when a search starts or while probing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_o |-> (state_q == stbs_pkg::ST_PROBE || (idle_o && start_i)))
    else $error("table read issued outside a search");

  // While probing the search range is never empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == stbs_pkg::ST_PROBE |-> (lo_q < hi_q && hi_q <= BW'(TABLE_DEPTH)))
    else $error("probe with an empty or oversized range");

  // A pending result is never overwritten before it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_ready_i) |=> (res_valid_q && $stable(res_q)))
    else $error("pending result changed");

  // A miss reports zero position and zero name.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_q.found) |-> (res_q.position == '0 && res_q.name == '0))
    else $error("miss result carries data");

endmodule : stbs_search

`default_nettype wire

// ===== hdl/sorted_table_binary_search_unit.sv =====
// ----------------------------------------------------------------------------
// Sorted-table binary search unit
// Keeps a table of text keys and names and binary-searches it for a query.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake               Transfer carries
//  -------  ---------  ----------------------  ---------------------------------
//  cfg      in         cfg_valid_i/cfg_ready_o cfg_entry_count_i
//  in       in         in_valid_i/in_ready_o   kind_i, slot_i, key_text_i,
//                                              name_text_i
//  out      out        out_valid_o/out_ready_i found_o, position_o,
//                                              matched_name_o
//
// A load produces no output transfer.
// A search takes at most floor(log2(n)) + 1 probes for n searched entries
// (nine for a full table of 256), paced by the single read port of the key
// and name memories; the result is registered at the end of the last probe
// and the next item is taken on the following cycle.
// A search that finds no entries to probe goes to the miss state instead.
// Reset clears control state only; table entries are undefined until loaded,
// so there is no clearing pass.
// A finished search waits in its last probe or miss state while the output
// register still holds an untaken result; no new item is taken until idle.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_binary_search_unit #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned KEY_BYTES   = 8,
  parameter int unsigned NAME_BYTES  = 8
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Configuration write channel.
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [stbs_pkg::COUNT_W-1:0]    cfg_entry_count_i,
  // Input items.
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            kind_i,
  input  wire logic [stbs_pkg::SLOT_W-1:0]     slot_i,
  input  wire logic [stbs_pkg::KEY_W-1:0]      key_text_i,
  input  wire logic [stbs_pkg::NAME_W-1:0]     name_text_i,
  // Result items.
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic                                 found_o,
  output logic      [stbs_pkg::POS_W-1:0]      position_o,
  output logic      [stbs_pkg::NAME_W-1:0]     matched_name_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned KW = 8 * KEY_BYTES;
  localparam int unsigned NW = 8 * NAME_BYTES;

  logic [stbs_pkg::COUNT_W-1:0] entry_count_q;

  logic              in_xfer;
  logic              search_idle;
  logic [KW-1:0]     key_canon;
  logic              key_live;
  logic [AW+7:0]     slot_ext;
  logic              load_en;

  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [KW-1:0]     rd_key;
  logic [NW-1:0]     rd_name;
  stbs_pkg::result_t res;

  // The register is always ready; the user must write it only while the unit is idle, the unit does not enforce it.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else if (cfg_valid_i) begin
      entry_count_q <= cfg_entry_count_i;
    end
  end

  assign in_ready_o = search_idle;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Keys compare like C strings: the first byte sits highest, and every byte
  // after the first zero byte is cleared so that a plain unsigned compare
  // gives the lexicographic order.
  always_comb begin
    key_live  = 1'b1;
    key_canon = '0;
    for (int unsigned i = 0; i < KEY_BYTES; i++) begin
      if (key_text_i[8*(KEY_BYTES-1-i) +: 8] == 8'd0) begin
        key_live = 1'b0;
      end
      if (key_live) begin
        key_canon[8*(KEY_BYTES-1-i) +: 8] = key_text_i[8*(KEY_BYTES-1-i) +: 8];
      end
    end
  end

  // A load to a slot beyond the table is dropped.
  assign slot_ext = {AW'(0), slot_i};
  assign load_en  = in_xfer && (kind_i == stbs_pkg::KIND_LOAD) &&
                    (slot_ext < (AW+8)'(TABLE_DEPTH));

  stbs_ram #(
    .WIDTH (KW),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk_i     (clk_i),
    .wr_en_i   (load_en),
    .wr_addr_i (slot_ext[AW-1:0]),
    .wr_data_i (key_canon),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_key)
  );

  stbs_ram #(
    .WIDTH (NW),
    .DEPTH (TABLE_DEPTH)
  ) u_name_ram (
    .clk_i     (clk_i),
    .wr_en_i   (load_en),
    .wr_addr_i (slot_ext[AW-1:0]),
    .wr_data_i (name_text_i[NW-1:0]),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_name)
  );

  stbs_search #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BYTES   (KEY_BYTES),
    .NAME_BYTES  (NAME_BYTES)
  ) u_search (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (in_xfer && (kind_i == stbs_pkg::KIND_SEARCH)),
    .query_i       (key_canon),
    .entry_count_i (entry_count_q),
    .idle_o        (search_idle),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .rd_key_i      (rd_key),
    .rd_name_i     (rd_name),
    .res_valid_o   (out_valid_o),
    .res_ready_i   (out_ready_i),
    .res_o         (res)
  );

  assign found_o        = res.found;
  assign position_o     = res.position;
  assign matched_name_o = res.name;

endmodule : sorted_table_binary_search_unit

`default_nettype wire
